@@ rtl/indexed_sprite_stream_decoder_assert.svh @@
// Assertion macros for the indexed sprite stream decoder.
`ifndef INDEXED_SPRITE_STREAM_DECODER_ASSERT_SVH
`define INDEXED_SPRITE_STREAM_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ISSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property failed");

// Check that a condition never holds outside reset.
`define ISSD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ISSD_ASSERT(lbl, clk, rst, prop)
`define ISSD_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ rtl/issd_pkg.sv @@
// Constants, codes and types of the indexed sprite stream decoder.
`timescale 1ns / 1ps

package issd_pkg;

   // Largest frame side accepted
   localparam int unsigned MAX_SIDE = 4096;
   localparam int unsigned SIDE_W = 13;
   localparam int unsigned PIX_W = 25;
   localparam int unsigned RUN_W = 33;
   localparam int unsigned PAL_DEPTH = 256;
   localparam int unsigned PAL_AW = $clog2(PAL_DEPTH);

   // Result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   // File header layout (field numbers of the 32-bit header words)
   localparam int unsigned HF_VERSION = 0;
   localparam int unsigned HF_ALPHA = 2;
   localparam int unsigned HF_WIDTH = 4;
   localparam int unsigned HF_HEIGHT = 5;
   localparam int unsigned HF_FRAMES = 6;
   localparam int unsigned HF_COUNT = 9;
   localparam logic [31:0] VERSION = 32'd2;
   localparam logic [31:0] ALPHA_MAX = 32'd3;

   // Frame type codes
   localparam logic [31:0] FT_SINGLE = 32'd0;
   localparam logic [31:0] FT_GROUP = 32'd1;

   // Frame header layout
   localparam int unsigned FF_WIDTH = 2;
   localparam int unsigned FF_HEIGHT = 3;
   localparam int unsigned FF_COUNT = 4;

   // Alpha modes
   localparam logic [1:0] AM_INDEX = 2'd2;
   localparam logic [1:0] AM_TEST = 2'd3;
   localparam logic [7:0] CLEAR_INDEX = 8'd255;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_MAGIC       = 4'd1,
      ST_VERSION     = 4'd2,
      ST_FRAME_COUNT = 4'd3,
      ST_ALPHA_MODE  = 4'd4,
      ST_HDR_SIZE    = 4'd5,
      ST_EMPTY_PAL   = 4'd6,
      ST_FRAME_TYPE  = 4'd7,
      ST_GROUP_COUNT = 4'd8,
      ST_FRAME_SIZE  = 4'd9,
      ST_INDEX_RANGE = 4'd10,
      ST_TRUNCATED   = 4'd11
   } status_type;

   // Work of one byte, handed to the result stage
   typedef struct packed {
      logic              pix;
      logic              sta;
      logic [7:0]        alpha;
      status_type        code;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic              eor;
   } stage_type;

   // One result beat
   typedef struct packed {
      logic              kind;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      status_type        code;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic              eor;
   } item_type;

   // Expected byte of the magic word "IDSP"
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      unique case (idx)
         2'd0: m = 8'h49;
         2'd1: m = 8'h44;
         2'd2: m = 8'h53;
         default: m = 8'h50;
      endcase
      return m;
   endfunction

   // Zero or negative as a signed 32-bit word
   function automatic logic not_positive(input logic [31:0] v);
      return (v == 32'd0) || v[31];
   endfunction

endpackage

@@ rtl/indexed_sprite_stream_decoder.sv @@
// Top level of the indexed sprite stream decoder: byte parser, palette and result queue.
//
//  channel | dir | beat                 | payload
//  req_    | in  | one file byte        | tdata: data_byte; tlast: last_byte
//  rsp_    | out | one pixel or status  | tuser: result_kind; tdata: rgba, code, size;
//          |     |                      | tlast: end_of_run
//
// One byte is taken per cycle while req_tready is high; the parser state updates at the
// beat and the palette read is registered, and the queue is filled from those registers.
// A byte gives at most two results (last pixel and its status), pushed together into
// a four-entry queue; req_tready drops while the queue could not take two more.
// Reset is synchronous and needs no clearing pass; the palette is written before use.
// A stall on rsp_ holds the queue head; input continues while the queue can take two more.
`timescale 1ns / 1ps

module indexed_sprite_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [35:32] status_code,
                                    // [48:36] frame_width, [61:49] frame_height
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast
);

`include "indexed_sprite_stream_decoder_assert.svh"

   typedef enum logic [3:0] {
      PH_MAGIC, PH_HDR, PH_PALSIZE, PH_PAL, PH_FTYPE,
      PH_GCOUNT, PH_SKIP, PH_FHDR, PH_PIX, PH_DONE
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [1:0]                     idx_ff, idx_in;
   logic [23:0]                    fa_ff, fa_in;
   logic [issd_pkg::RUN_W-1:0]     rc_ff, rc_in;
   logic [15:0]                    pal_cnt_ff, pal_cnt_in;
   logic [15:0]                    color_ff, color_in;
   logic [1:0]                     amode_ff, amode_in;
   logic [issd_pkg::SIDE_W-1:0]    width_ff, width_in;
   logic [issd_pkg::SIDE_W-1:0]    height_ff, height_in;
   logic [issd_pkg::PIX_W-1:0]     pix_left_ff, pix_left_in;
   issd_pkg::stage_type            s1_ff, s1_in;

   logic [23:0]                    palette_mem [issd_pkg::PAL_DEPTH];
   logic [23:0]                    pal_rd_ff;
   logic                           pal_we;

   issd_pkg::item_type             fifo_mem [issd_pkg::FIFO_DEPTH];
   logic [issd_pkg::FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [issd_pkg::CNT_W-1:0]     count_ff;

   logic                           req_accept, rsp_accept;
   logic [7:0]                     b;
   logic [31:0]                    v;
   logic [issd_pkg::RUN_W-1:0]     rc_inc;
   logic [2*issd_pkg::SIDE_W-1:0]  area;
   logic [issd_pkg::PIX_W-1:0]     pix_dec;

   issd_pkg::item_type             pix_item, sta_item, slot0;
   logic                           push0, push1;
   logic [1:0]                     push_n;
   logic [issd_pkg::CNT_W:0]       room_need;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign b = req_tdata;
   assign v = {b, fa_ff};
   assign rc_inc = rc_ff + issd_pkg::RUN_W'(1);
   assign area = width_ff * v[issd_pkg::SIDE_W-1:0];
   assign pix_dec = pix_left_ff - issd_pkg::PIX_W'(1);

   // Parse one byte: next state and the results it causes
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      fa_in       = fa_ff;
      rc_in       = rc_ff;
      pal_cnt_in  = pal_cnt_ff;
      color_in    = color_ff;
      amode_in    = amode_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      pix_left_in = pix_left_ff;
      pal_we      = 1'b0;
      s1_in       = '0;
      s1_in.code  = issd_pkg::ST_OK;
      s1_in.eor   = req_tlast;

      // Collect field bytes lane by lane
      unique case (idx_ff)
         2'd0: fa_in[7:0] = b;
         2'd1: fa_in[15:8] = b;
         2'd2: fa_in[23:16] = b;
         default: ;
      endcase

      if (phase_ff == PH_DONE) begin
         if (req_tlast) begin
            phase_in = PH_MAGIC;
         end
      end else begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (b != issd_pkg::magic_byte(idx_ff)) begin
                  s1_in.sta  = 1'b1;
                  s1_in.code = issd_pkg::ST_MAGIC;
               end else if (idx_ff == 2'd3) begin
                  idx_in   = 2'd0;
                  rc_in    = '0;
                  phase_in = PH_HDR;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_HDR: begin
               if (idx_ff != 2'd3) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in = 2'd0;
                  if (rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_VERSION) &&
                      v != issd_pkg::VERSION) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_VERSION;
                  end else if (rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_ALPHA) &&
                               v > issd_pkg::ALPHA_MAX) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_ALPHA_MODE;
                  end else if ((rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_WIDTH) ||
                                rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_HEIGHT)) &&
                               issd_pkg::not_positive(v)) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_HDR_SIZE;
                  end else if (rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_FRAMES) &&
                               issd_pkg::not_positive(v)) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_FRAME_COUNT;
                  end else begin
                     if (rc_ff == issd_pkg::RUN_W'(issd_pkg::HF_ALPHA)) begin
                        amode_in = v[1:0];
                     end
                     if (rc_inc >= issd_pkg::RUN_W'(issd_pkg::HF_COUNT)) begin
                        rc_in    = '0;
                        phase_in = PH_PALSIZE;
                     end else begin
                        rc_in = rc_inc;
                     end
                  end
               end
            end
            PH_PALSIZE: begin
               if (idx_ff == 2'd0) begin
                  idx_in = 2'd1;
               end else begin
                  idx_in     = 2'd0;
                  pal_cnt_in = {b, fa_ff[7:0]};
                  if ({b, fa_ff[7:0]} == 16'd0) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_EMPTY_PAL;
                  end else begin
                     rc_in    = '0;
                     phase_in = PH_PAL;
                  end
               end
            end
            PH_PAL: begin
               if (idx_ff == 2'd0) begin
                  color_in[7:0] = b;
                  idx_in        = 2'd1;
               end else if (idx_ff == 2'd1) begin
                  color_in[15:8] = b;
                  idx_in         = 2'd2;
               end else begin
                  idx_in = 2'd0;
                  pal_we = rc_ff < issd_pkg::RUN_W'(issd_pkg::PAL_DEPTH);
                  if (rc_inc >= issd_pkg::RUN_W'(pal_cnt_ff)) begin
                     rc_in    = '0;
                     phase_in = PH_FTYPE;
                  end else begin
                     rc_in = rc_inc;
                  end
               end
            end
            PH_FTYPE: begin
               if (idx_ff != 2'd3) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in = 2'd0;
                  if (v == issd_pkg::FT_SINGLE) begin
                     rc_in    = '0;
                     phase_in = PH_FHDR;
                  end else if (v == issd_pkg::FT_GROUP) begin
                     phase_in = PH_GCOUNT;
                  end else begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_FRAME_TYPE;
                  end
               end
            end
            PH_GCOUNT: begin
               if (idx_ff != 2'd3) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in = 2'd0;
                  if (issd_pkg::not_positive(v)) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_GROUP_COUNT;
                  end else begin
                     // Four interval bytes per group member
                     rc_in    = {v[30:0], 2'b00};
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               rc_in = rc_ff - issd_pkg::RUN_W'(1);
               if (rc_ff == issd_pkg::RUN_W'(1)) begin
                  phase_in = PH_FHDR;
               end
            end
            PH_FHDR: begin
               if (idx_ff != 2'd3) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in = 2'd0;
                  if (rc_ff >= issd_pkg::RUN_W'(issd_pkg::FF_WIDTH) &&
                      (issd_pkg::not_positive(v) || v > 32'(issd_pkg::MAX_SIDE))) begin
                     s1_in.sta  = 1'b1;
                     s1_in.code = issd_pkg::ST_FRAME_SIZE;
                  end else begin
                     if (rc_ff == issd_pkg::RUN_W'(issd_pkg::FF_WIDTH)) begin
                        width_in = v[issd_pkg::SIDE_W-1:0];
                     end
                     if (rc_ff == issd_pkg::RUN_W'(issd_pkg::FF_HEIGHT)) begin
                        height_in = v[issd_pkg::SIDE_W-1:0];
                     end
                     if (rc_inc >= issd_pkg::RUN_W'(issd_pkg::FF_COUNT)) begin
                        // The height arrives last, so it multiplies the held width
                        rc_in       = '0;
                        pix_left_in = area[issd_pkg::PIX_W-1:0];
                        phase_in    = PH_PIX;
                     end else begin
                        rc_in = rc_inc;
                     end
                  end
               end
            end
            PH_PIX: begin
               if ({8'd0, b} >= pal_cnt_ff) begin
                  s1_in.sta  = 1'b1;
                  s1_in.code = issd_pkg::ST_INDEX_RANGE;
               end else begin
                  s1_in.pix = 1'b1;
                  if (amode_ff == issd_pkg::AM_TEST) begin
                     s1_in.alpha = (b == issd_pkg::CLEAR_INDEX) ? 8'd0 : 8'd255;
                  end else if (amode_ff == issd_pkg::AM_INDEX) begin
                     s1_in.alpha = b;
                  end else begin
                     s1_in.alpha = 8'd255;
                  end
                  pix_left_in = pix_dec;
                  if (pix_dec == '0) begin
                     s1_in.sta    = 1'b1;
                     s1_in.code   = issd_pkg::ST_OK;
                     s1_in.width  = width_ff;
                     s1_in.height = height_ff;
                  end
               end
            end
            default: ;
         endcase

         if (s1_in.sta) begin
            phase_in = PH_DONE;
         end

         // Early end of file closes the run with a truncation status
         if (req_tlast) begin
            if (!s1_in.sta) begin
               s1_in.sta  = 1'b1;
               s1_in.code = issd_pkg::ST_TRUNCATED;
            end
            phase_in = PH_MAGIC;
         end
      end

      // Restart the parser after the last byte
      if (req_tlast) begin
         idx_in      = 2'd0;
         rc_in       = '0;
         pal_cnt_in  = '0;
         color_in    = '0;
         amode_in    = '0;
         width_in    = '0;
         height_in   = '0;
         pix_left_in = '0;
      end
   end

   // Advance parser state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         idx_ff      <= '0;
         rc_ff       <= '0;
         pal_cnt_ff  <= '0;
         amode_ff    <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         pix_left_ff <= '0;
         s1_ff       <= '0;
      end else begin
         s1_ff <= '0;
         if (req_accept) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            rc_ff       <= rc_in;
            pal_cnt_ff  <= pal_cnt_in;
            amode_ff    <= amode_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
            pix_left_ff <= pix_left_in;
            s1_ff       <= s1_in;
         end
      end
   end

   // Hold field and colour assembly
   always_ff @(posedge clock) begin
      if (req_accept) begin
         fa_ff    <= fa_in;
         color_ff <= color_in;
      end
   end

   // Palette: write at the third colour byte, registered read for pixels
   always_ff @(posedge clock) begin
      if (req_accept && pal_we) begin
         palette_mem[rc_ff[issd_pkg::PAL_AW-1:0]] <= {b, color_ff};
      end
      if (req_accept) begin
         pal_rd_ff <= palette_mem[b];
      end
   end

   // Form the results of the registered byte
   always_comb begin
      pix_item        = '0;
      pix_item.kind   = 1'b0;
      pix_item.red    = pal_rd_ff[7:0];
      pix_item.green  = pal_rd_ff[15:8];
      pix_item.blue   = pal_rd_ff[23:16];
      pix_item.alpha  = s1_ff.alpha;
      pix_item.code   = issd_pkg::ST_OK;

      sta_item        = '0;
      sta_item.kind   = 1'b1;
      sta_item.code   = s1_ff.code;
      sta_item.width  = s1_ff.width;
      sta_item.height = s1_ff.height;
      sta_item.eor    = s1_ff.eor;

      slot0  = s1_ff.pix ? pix_item : sta_item;
      push0  = s1_ff.pix || s1_ff.sta;
      push1  = s1_ff.pix && s1_ff.sta;
      push_n = {1'b0, push0} + {1'b0, push1};
   end

   // Keep room for two results of the next byte
   assign room_need  = {1'b0, count_ff} + (issd_pkg::CNT_W + 1)'(push_n);
   assign req_tready = room_need <= (issd_pkg::CNT_W + 1)'(issd_pkg::FIFO_DEPTH - 2);

   // Result queue storage
   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_mem[wr_ptr_ff] <= slot0;
      end
      if (push1) begin
         fifo_mem[wr_ptr_ff + issd_pkg::FIFO_AW'(1)] <= sta_item;
      end
   end

   // Result queue pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + issd_pkg::FIFO_AW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + issd_pkg::FIFO_AW'(rsp_accept);
         count_ff  <= count_ff + issd_pkg::CNT_W'(push_n) - issd_pkg::CNT_W'(rsp_accept);
      end
   end

   // Drive the head of the queue
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tuser  = fifo_mem[rd_ptr_ff].kind;
   assign rsp_tlast  = fifo_mem[rd_ptr_ff].eor;
   assign rsp_tdata  = {2'b00,
                        fifo_mem[rd_ptr_ff].height,
                        fifo_mem[rd_ptr_ff].width,
                        fifo_mem[rd_ptr_ff].code,
                        fifo_mem[rd_ptr_ff].alpha,
                        fifo_mem[rd_ptr_ff].blue,
                        fifo_mem[rd_ptr_ff].green,
                        fifo_mem[rd_ptr_ff].red};

   `ISSD_ASSERT(a_fifo_bound, clock, reset, count_ff <= issd_pkg::CNT_W'(issd_pkg::FIFO_DEPTH))
   `ISSD_ASSERT(a_last_restarts, clock, reset, (req_accept && req_tlast) |=> (phase_ff == PH_MAGIC))
   `ISSD_ASSERT(a_done_silent, clock, reset, (req_accept && phase_ff == PH_DONE) |=> !(s1_ff.pix || s1_ff.sta))
   `ISSD_ASSERT(a_pixel_phase, clock, reset, s1_ff.pix |-> ($past(phase_ff) == PH_PIX))
   `ISSD_NEVER(a_no_push_overflow, clock, reset, push0 && (count_ff > issd_pkg::CNT_W'(issd_pkg::FIFO_DEPTH - 2)) && !rsp_accept && push1)

endmodule

@@ tb/sv/issd_stream_checker.sv @@
// Checker for the sprite decoder: follows the byte stream, predicts result beats, compares.
`timescale 1ns / 1ps

module issd_stream_checker
   import issd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
                                    // [35:32] status_code, [48:36] frame_width,
                                    // [61:49] frame_height
   input  logic        rsp_tuser,   // [0] result_kind
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          due_count,
   output int          parsed_count,
   output int          result_count
);

   typedef enum logic [3:0] {
      P_MAGIC, P_HEADER, P_PAL_SIZE, P_PALETTE, P_FRAME_TYPE,
      P_GROUP_COUNT, P_SKIP, P_FRAME_HDR, P_PIXELS, P_DONE
   } phase_type;

   // "IDSP", first byte in the lowest bits
   localparam logic [31:0] SIGNATURE = 32'h5053_4449;

   phase_type         phase;
   logic [1:0]        byte_idx;
   logic [31:0]       word_acc;
   logic [33:0]       run_cnt;
   logic [15:0]       pal_count;
   logic [15:0]       colour_acc;
   logic [23:0]       palette [PAL_DEPTH];
   logic [1:0]        alpha_mode;
   logic [SIDE_W-1:0] width_q;
   logic [SIDE_W-1:0] height_q;
   logic [PIX_W-1:0]  pix_left;
   logic              closed;

   item_type          due_results [$];
   int                fails = 0;
   int                parsed = 0;
   int                results = 0;

   initial begin
      foreach (palette[i]) palette[i] = '0;
   end

   // Return the parser to the start of a file; the palette is kept
   function automatic void restart_parser();
      phase      = P_MAGIC;
      byte_idx   = '0;
      word_acc   = '0;
      run_cnt    = '0;
      pal_count  = '0;
      colour_acc = '0;
      alpha_mode = '0;
      width_q    = '0;
      height_q   = '0;
      pix_left   = '0;
      closed     = 1'b0;
   endfunction

   // Add a byte to a little-endian field; true once all nbytes are in
   function automatic bit gather(input logic [7:0] b, input int nbytes);
      word_acc = word_acc | (32'(b) << (8 * byte_idx));
      if (byte_idx + 1 >= nbytes) begin
         byte_idx = '0;
         return 1'b1;
      end
      byte_idx = byte_idx + 1'b1;
      return 1'b0;
   endfunction

   function automatic bit below_one(input logic [31:0] v);
      return (v == 32'd0) || v[31];
   endfunction

   // Queue a status beat and close the file
   function automatic void post_status(input status_type code, input logic last);
      item_type r;
      r      = '0;
      r.kind = 1'b1;
      r.code = code;
      r.eor  = last;
      if (code == ST_OK) begin
         r.width  = width_q;
         r.height = height_q;
      end
      due_results.push_back(r);
      results++;
      closed = 1'b1;
      phase  = P_DONE;
   endfunction

   // Advance the parser by one accepted byte and queue the beats it causes
   function automatic void parse_file_byte(input logic [7:0] b, input logic last);
      logic [31:0] v;
      logic [23:0] colour;
      item_type    r;
      if (closed) begin
         if (last) restart_parser();
         return;
      end
      parsed++;
      case (phase)
         P_MAGIC: begin
            if (b != SIGNATURE[8*byte_idx +: 8]) begin
               post_status(ST_MAGIC, last);
            end else if (byte_idx == 2'd3) begin
               byte_idx = '0;
               run_cnt  = '0;
               phase    = P_HEADER;
            end else begin
               byte_idx = byte_idx + 1'b1;
            end
         end
         P_HEADER: begin
            if (gather(b, 4)) begin
               v        = word_acc;
               word_acc = '0;
               if (run_cnt == HF_VERSION && v != VERSION) begin
                  post_status(ST_VERSION, last);
               end else if (run_cnt == HF_ALPHA && v > ALPHA_MAX) begin
                  post_status(ST_ALPHA_MODE, last);
               end else if ((run_cnt == HF_WIDTH || run_cnt == HF_HEIGHT) && below_one(v)) begin
                  post_status(ST_HDR_SIZE, last);
               end else if (run_cnt == HF_FRAMES && below_one(v)) begin
                  post_status(ST_FRAME_COUNT, last);
               end else begin
                  if (run_cnt == HF_ALPHA) alpha_mode = v[1:0];
                  run_cnt = run_cnt + 1'b1;
                  if (run_cnt >= HF_COUNT) begin
                     run_cnt = '0;
                     phase   = P_PAL_SIZE;
                  end
               end
            end
         end
         P_PAL_SIZE: begin
            if (gather(b, 2)) begin
               pal_count = word_acc[15:0];
               word_acc  = '0;
               if (pal_count == 16'd0) begin
                  post_status(ST_EMPTY_PAL, last);
               end else begin
                  run_cnt = '0;
                  phase   = P_PALETTE;
               end
            end
         end
         P_PALETTE: begin
            // three bytes per entry; entries past the store are read and dropped
            if (byte_idx == 2'd0) begin
               colour_acc = {8'd0, b};
               byte_idx   = 2'd1;
            end else if (byte_idx == 2'd1) begin
               colour_acc[15:8] = b;
               byte_idx         = 2'd2;
            end else begin
               byte_idx = '0;
               if (run_cnt < PAL_DEPTH) palette[run_cnt[PAL_AW-1:0]] = {b, colour_acc};
               run_cnt = run_cnt + 1'b1;
               if (run_cnt >= pal_count) begin
                  run_cnt = '0;
                  phase   = P_FRAME_TYPE;
               end
            end
         end
         P_FRAME_TYPE: begin
            if (gather(b, 4)) begin
               v        = word_acc;
               word_acc = '0;
               if (v == FT_SINGLE) begin
                  run_cnt = '0;
                  phase   = P_FRAME_HDR;
               end else if (v == FT_GROUP) begin
                  phase = P_GROUP_COUNT;
               end else begin
                  post_status(ST_FRAME_TYPE, last);
               end
            end
         end
         P_GROUP_COUNT: begin
            if (gather(b, 4)) begin
               v        = word_acc;
               word_acc = '0;
               if (below_one(v)) begin
                  post_status(ST_GROUP_COUNT, last);
               end else begin
                  run_cnt = {v, 2'b00};
                  phase   = P_SKIP;
               end
            end
         end
         P_SKIP: begin
            run_cnt = run_cnt - 1'b1;
            if (run_cnt == '0) phase = P_FRAME_HDR;
         end
         P_FRAME_HDR: begin
            if (gather(b, 4)) begin
               v        = word_acc;
               word_acc = '0;
               if (run_cnt >= FF_WIDTH && (below_one(v) || v > MAX_SIDE)) begin
                  post_status(ST_FRAME_SIZE, last);
               end else begin
                  if (run_cnt == FF_WIDTH) width_q = v[SIDE_W-1:0];
                  else if (run_cnt > FF_WIDTH) height_q = v[SIDE_W-1:0];
                  run_cnt = run_cnt + 1'b1;
                  if (run_cnt >= FF_COUNT) begin
                     run_cnt  = '0;
                     pix_left = PIX_W'(width_q) * PIX_W'(height_q);
                     phase    = P_PIXELS;
                  end
               end
            end
         end
         P_PIXELS: begin
            if (b >= pal_count) begin
               post_status(ST_INDEX_RANGE, last);
            end else begin
               colour  = palette[b];
               r       = '0;
               r.red   = colour[7:0];
               r.green = colour[15:8];
               r.blue  = colour[23:16];
               if (alpha_mode == AM_TEST) r.alpha = (b == CLEAR_INDEX) ? 8'd0 : 8'd255;
               else if (alpha_mode == AM_INDEX) r.alpha = b;
               else r.alpha = 8'd255;
               due_results.push_back(r);
               results++;
               pix_left = pix_left - 1'b1;
               if (pix_left == '0) post_status(ST_OK, last);
            end
         end
         default: ;
      endcase
      // an early end of file closes with a truncation status
      if (last) begin
         if (!closed) post_status(ST_TRUNCATED, 1'b1);
         restart_parser();
      end
   endfunction

   function automatic void check_field(input string name, input logic [12:0] want,
                                       input logic [12:0] got);
      if (got !== want) begin
         fails++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Predict on every byte beat, then compare every result beat with the oldest prediction
   always @(posedge clock) begin : watch
      item_type want;
      if (reset) begin
         restart_parser();
         due_results.delete();
      end else begin
         if (req_tvalid && req_tready) parse_file_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               fails++;
               $error("result beat with nothing expected: tuser %0d tdata %h",
                      rsp_tuser, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               check_field("result_kind", 13'(want.kind), 13'(rsp_tuser));
               check_field("red", 13'(want.red), 13'(rsp_tdata[7:0]));
               check_field("green", 13'(want.green), 13'(rsp_tdata[15:8]));
               check_field("blue", 13'(want.blue), 13'(rsp_tdata[23:16]));
               check_field("alpha", 13'(want.alpha), 13'(rsp_tdata[31:24]));
               check_field("status_code", 13'(want.code), 13'(rsp_tdata[35:32]));
               check_field("frame_width", want.width, rsp_tdata[48:36]);
               check_field("frame_height", want.height, rsp_tdata[61:49]);
               check_field("end_of_run", 13'(want.eor), 13'(rsp_tlast));
            end
         end
      end
      fail_count   <= fails;
      due_count    <= due_results.size();
      parsed_count <= parsed;
      result_count <= results;
   end

endmodule

@@ tb/sv/tb_indexed_sprite_stream_decoder.sv @@
// Testbench top for the sprite decoder: builds sprite files, drives them and gives the verdict.
`timescale 1ns / 1ps

module tb_indexed_sprite_stream_decoder;
   import issd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [7:0] red .. [61:49] frame_height
   logic        rsp_tuser;         // [0] result_kind
   logic        rsp_tlast;

   int fail_count;
   int due_count;
   int parsed_count;
   int result_count;

   // Shape of one sprite file; the defaults make a well-formed one
   typedef struct {
      int          bad_magic;   // signature byte to spoil, -1 for none
      logic [31:0] version;
      logic [31:0] alpha;
      logic [31:0] hdr_w;
      logic [31:0] hdr_h;
      logic [31:0] frames;
      logic [15:0] pal_size;
      logic [31:0] ftype;
      logic [31:0] groups;
      logic [31:0] fw;
      logic [31:0] fh;
      int          bad_pixel;   // pixel given an index past the palette, -1 for none
      int          cut;         // >0 keep that many bytes, <0 drop that many from the end
      int          tail;        // junk bytes after the frame
   } sprite_spec;

   logic [7:0] file_bytes [$];
   int         pixel_start;
   int         burst_left = 0;
   int         holds_asked = 0;
   int         holds_served = 0;

   indexed_sprite_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   issd_stream_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .due_count    (due_count),
      .parsed_count (parsed_count),
      .result_count (result_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #20_000_000;
      $display("tb_indexed_sprite_stream_decoder: done, errors");
      $finish;
   end

   // Receiver: windows of differing readiness, plus a long hold-off when asked
   initial begin : receiver
      int span;
      int pct;
      forever begin
         if (holds_served != holds_asked) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            holds_served++;
         end else begin
            pct  = 25 * $urandom_range(1, 4);
            span = $urandom_range(1, 48);
            repeat (span) begin
               rsp_tready <= ($urandom_range(1, 100) <= pct);
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic [31:0] bad_size();
      return $urandom_range(0, 1) ? 32'd0 : (32'h8000_0000 | $urandom());
   endfunction

   function automatic sprite_spec good_spec();
      sprite_spec s;
      s.bad_magic = -1;
      s.version   = VERSION;
      s.alpha     = $urandom_range(0, ALPHA_MAX);
      s.hdr_w     = $urandom_range(1, 512);
      s.hdr_h     = $urandom_range(1, 512);
      s.frames    = $urandom_range(1, 8);
      s.pal_size  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 200)
                                                 : $urandom_range(1, 16);
      s.ftype     = $urandom_range(0, 1) ? FT_GROUP : FT_SINGLE;
      s.groups    = $urandom_range(1, 3);
      s.fw        = $urandom_range(1, 4);
      s.fh        = $urandom_range(1, 4);
      s.bad_pixel = -1;
      s.cut       = 0;
      s.tail      = $urandom_range(0, 2);
      return s;
   endfunction

   function automatic void add_bytes(input logic [31:0] w, input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(w[8*i +: 8]);
   endfunction

   // Lay out a whole sprite file in file_bytes
   function automatic void build_file(input sprite_spec s);
      string       sig = "IDSP";
      logic [31:0] w;
      int          npix;
      int          top;
      file_bytes.delete();
      for (int i = 0; i < 4; i++)
         file_bytes.push_back((i == s.bad_magic) ? sig[i] ^ 8'($urandom_range(1, 255)) : sig[i]);
      for (int k = 0; k < HF_COUNT; k++) begin
         case (k)
            HF_VERSION: w = s.version;
            HF_ALPHA:   w = s.alpha;
            HF_WIDTH:   w = s.hdr_w;
            HF_HEIGHT:  w = s.hdr_h;
            HF_FRAMES:  w = s.frames;
            default:    w = $urandom();
         endcase
         add_bytes(w, 4);
      end
      add_bytes(32'(s.pal_size), 2);
      for (int i = 0; i < 3 * s.pal_size; i++) file_bytes.push_back(8'($urandom()));
      add_bytes(s.ftype, 4);
      if (s.ftype == FT_GROUP) begin
         add_bytes(s.groups, 4);
         if (!s.groups[31] && s.groups != 0 && s.groups < 64)
            for (int i = 0; i < 4 * s.groups; i++) file_bytes.push_back(8'($urandom()));
      end
      add_bytes($urandom(), 4);
      add_bytes($urandom(), 4);
      add_bytes(s.fw, 4);
      add_bytes(s.fh, 4);
      if (s.fw >= 1 && s.fw <= MAX_SIDE && s.fh >= 1 && s.fh <= MAX_SIDE) npix = s.fw * s.fh;
      else npix = 3;
      top = (s.pal_size == 0 || s.pal_size > PAL_DEPTH) ? PAL_DEPTH - 1 : s.pal_size - 1;
      pixel_start = file_bytes.size();
      for (int i = 0; i < npix; i++) begin
         if (i == s.bad_pixel) file_bytes.push_back(8'($urandom_range(s.pal_size, 255)));
         else file_bytes.push_back(8'($urandom_range(0, top)));
      end
      for (int i = 0; i < s.tail; i++) file_bytes.push_back(8'($urandom()));
      if (s.cut > 0) begin
         while (file_bytes.size() > s.cut) void'(file_bytes.pop_back());
      end else begin
         for (int i = 0; i < -s.cut && file_bytes.size() > 1; i++) void'(file_bytes.pop_back());
      end
   endfunction

   // Send file_bytes in bursts, marking the final byte; ask for a hold-off at hold_at
   task automatic send_file(input int hold_at);
      int gap;
      foreach (file_bytes[i]) begin
         if (i == hold_at) holds_asked++;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tdata  <= file_bytes[i];
         req_tlast  <= (i == file_bytes.size() - 1);
         do @(posedge clock); while (!req_tready);
      end
   endtask

   task automatic run_spec(input sprite_spec s);
      build_file(s);
      send_file(-1);
   endtask

   // Hold the sender until every predicted beat has come out
   task automatic drain_wait();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   initial begin : stimulus
      sprite_spec s;
      int         parsed_base;
      int         results_base;
      int         pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain files in alpha modes 0 and 1, single and grouped, and one with the largest header sides
      s = good_spec(); s.alpha = 0; s.ftype = FT_SINGLE; s.tail = 0; run_spec(s);
      s = good_spec(); s.alpha = 1; s.ftype = FT_GROUP; s.groups = 2; s.tail = 5; run_spec(s);
      s = good_spec(); s.hdr_w = 32'h7FFF_FFFF; s.hdr_h = 32'h7FFF_FFFF; run_spec(s);

      // signature spoilt at each byte; one-byte files, good and bad
      for (int i = 0; i < 4; i++) begin
         s = good_spec(); s.bad_magic = i; s.cut = 6; run_spec(s);
      end
      file_bytes = '{8'h49}; send_file(-1);
      file_bytes = '{8'h00}; send_file(-1);

      // header field faults
      s = good_spec(); s.version = 32'd3; s.cut = 12; run_spec(s);
      s = good_spec(); s.alpha = 32'd4; s.cut = 16; run_spec(s);
      s = good_spec(); s.alpha = 32'hFFFF_FFFF; run_spec(s);
      s = good_spec(); s.hdr_w = 32'd0; s.cut = 26; run_spec(s);
      s = good_spec(); s.hdr_h = 32'h8000_0000; s.cut = 30; run_spec(s);
      s = good_spec(); s.frames = 32'd0; s.cut = 34; run_spec(s);
      s = good_spec(); s.frames = 32'hFFFF_FFFF; run_spec(s);
      s = good_spec(); s.pal_size = 16'd0; s.cut = 44; run_spec(s);

      // frame type, group count and frame size faults
      s = good_spec(); s.ftype = 32'd2; run_spec(s);
      s = good_spec(); s.ftype = 32'hFFFF_FFFF; run_spec(s);
      s = good_spec(); s.ftype = FT_GROUP; s.groups = 32'd0; run_spec(s);
      s = good_spec(); s.ftype = FT_GROUP; s.groups = 32'h8000_0000; run_spec(s);
      s = good_spec(); s.fw = 32'd0; run_spec(s);
      s = good_spec(); s.fh = MAX_SIDE + 1; run_spec(s);
      s = good_spec(); s.fw = 32'hFFFF_FFFE; run_spec(s);

      // index past the palette after some pixels have gone out
      s = good_spec(); s.pal_size = 16'd5; s.fw = 2; s.fh = 2; s.bad_pixel = 2; run_spec(s);

      // early ends: in the header, the palette, the skipped table and the pixels
      s = good_spec(); s.cut = 20; run_spec(s);
      s = good_spec(); s.pal_size = 16'd10; s.cut = 50; run_spec(s);
      s = good_spec(); s.pal_size = 16'd2; s.ftype = FT_GROUP; s.groups = 3; s.cut = 60;
      run_spec(s);
      s = good_spec(); s.fw = 3; s.fh = 3; s.tail = 0; s.cut = -4; run_spec(s);

      // oversized palette with alpha test, widest frame; the receiver holds off mid-frame
      s = good_spec(); s.alpha = AM_TEST; s.pal_size = 16'd258; s.ftype = FT_SINGLE;
      s.fw = MAX_SIDE; s.fh = 1; s.tail = 0;
      build_file(s);
      send_file(pixel_start + 16);

      // full palette with index alpha, tallest frame
      s = good_spec(); s.alpha = AM_INDEX; s.pal_size = 16'(PAL_DEPTH); s.fw = 1;
      s.fh = MAX_SIDE; s.tail = 0;
      run_spec(s);
      drain_wait();

      // random files: mostly well-formed, some spoilt, some noise
      parsed_base  = parsed_count;
      results_base = result_count;
      while (parsed_count - parsed_base < 550 || result_count - results_base < 60) begin
         s    = good_spec();
         pick = $urandom_range(0, 23);
         case (pick)
            0: s.bad_magic = $urandom_range(0, 3);
            1: s.version = VERSION + $urandom_range(1, 32'hFFFF_FFFF);
            2: s.alpha = $urandom_range(ALPHA_MAX + 1, 32'hFFFF_FFFF);
            3: if ($urandom_range(0, 1)) s.hdr_w = bad_size(); else s.hdr_h = bad_size();
            4: s.frames = bad_size();
            5: s.pal_size = 16'd0;
            6: s.ftype = $urandom_range(FT_GROUP + 1, 32'hFFFF_FFFF);
            7: begin
               s.ftype  = FT_GROUP;
               s.groups = bad_size();
            end
            8: begin
               if ($urandom_range(0, 1)) s.fw = bad_size();
               else s.fh = $urandom_range(MAX_SIDE + 1, 32'h7FFF_FFFF);
            end
            9: s.bad_pixel = $urandom_range(0, s.fw * s.fh - 1);
            10: s.cut = $urandom_range(0, 1) ? $urandom_range(1, 70) : -$urandom_range(1, 20);
            default: ;
         endcase
         if (pick == 11) begin
            // noise, sometimes behind a valid signature
            file_bytes.delete();
            if ($urandom_range(0, 1)) add_bytes(32'h5053_4449, 4);
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom()));
            send_file(-1);
         end else begin
            run_spec(s);
         end
         if ($urandom_range(0, 7) == 0) drain_wait();
      end

      drain_wait();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("tb_indexed_sprite_stream_decoder: done, clean");
      else
         $display("tb_indexed_sprite_stream_decoder: done, errors");
      $finish;
   end

endmodule
